[rtl/core/uvst_pkg.sv]
// Package for the unique value set table: payload structs, action codes,
// controller states and the per-cell control struct.
// No dependencies; every other file of the block imports it.
package uvst_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] item_value;
    } uvst_in_t;

    typedef struct packed {
        logic       was_present;
        logic [3:0] position;
        logic [4:0] entry_count;
        logic       dropped;
    } uvst_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic cmp;   // register the compare of the key against the entry
        logic ins;   // append the key at the slot equal to the count
        logic del;   // close the gap at the matched slot
    } cell_ctl_t;

endpackage

[rtl/core/uvst_cell.sv]
// One slot of the value table: holds an entry, compares it with the key
// and takes its upper neighbor's entry when a delete closes a gap.
// Depends on uvst_pkg.
module uvst_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  uvst_pkg::cell_ctl_t                ctl,
    input  logic [uvst_pkg::DATA_W-1:0]        key,
    input  logic [uvst_pkg::DATA_W-1:0]        upper_value,
    input  logic [IDX_W-1:0]                   hit_idx,
    input  logic [CNT_W-1:0]                   count,
    output logic [uvst_pkg::DATA_W-1:0]        value,
    output logic                               match
);
    import uvst_pkg::*;

    localparam logic [CNT_W-1:0] MY_POS   = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] NEXT_POS = CNT_W'(INDEX + 1);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic              match_reg;
    logic              match_next;
    logic [CNT_W-1:0]  hit_pos;

    assign hit_pos = CNT_W'(hit_idx);

    always_comb
    begin
        val_next = val_reg;
        if (ctl.ins && (count == MY_POS))
        begin
            val_next = key;
        end
        else if (ctl.del && (MY_POS >= hit_pos) && (NEXT_POS < count))
        begin
            val_next = upper_value;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctl.cmp)
        begin
            match_next = (val_reg == key) && (MY_POS < count);
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign value = val_reg;
    assign match = match_reg;

endmodule

[rtl/core/unique_value_set_table.sv]
// Top level of the unique value set table: controller, row of table cells
// and result register.
// Depends on uvst_pkg and uvst_cell.

// The table keeps up to CAPACITY distinct 32-bit values in the order they
// were inserted. A command beat is taken at a rising edge where start is high
// and busy is low. Busy then stays high through the compare and update
// states: in the compare state, every cell compares its entry with the value
// and registers the outcome; in the update state, the match flags are merged
// into a hit and a position, and the row appends, shifts or holds. The result
// beat appears on result with done high for exactly one cycle, the cycle right
// after the update, and the receiver cannot hold it off. A new command may be
// started in that same cycle but not earlier: the block takes no new command
// while the registered compare stage in the cells or the update stage is busy
// with the last one. A delete shifts every later entry down one slot in the
// update cycle, keeping their order. An insert of a new value into a full
// table stores nothing and reports dropped. Position is the low four bits of
// the slot index and entry_count the low five bits of the count. Entries at
// or above the count never match, so the table needs no clearing after reset.
module unique_value_set_table #(
    parameter int CAPACITY = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  uvst_pkg::uvst_in_t  cmd,
    output logic                done,
    output uvst_pkg::uvst_out_t result
);
    import uvst_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    // Controller state.
    state_t     state_reg;
    state_t     state_next;
    logic       accept;

    // Captured command.
    uvst_in_t   item_reg;

    // Stored count.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Result beat.
    uvst_out_t  res_reg;
    uvst_out_t  res_next;
    logic       done_reg;
    logic       done_next;

    // Row of cells.
    cell_ctl_t                ctl;
    logic [DATA_W-1:0]        key;
    logic [DATA_W-1:0]        cell_value [CAPACITY];
    logic [CAPACITY-1:0]      cell_match;

    // Merge of the match flags and update decisions.
    logic                     hit;
    logic [IDX_W-1:0]         hit_idx;
    logic                     is_insert;
    logic                     is_delete;
    logic                     do_ins;
    logic                     do_del;
    logic                     do_drop;
    logic [IDX_W-1:0]         pos;
    logic [IDX_W+3:0]         pos_wide;
    logic [CNT_W+4:0]         cnt_wide;

    assign accept = start && (state_reg == ST_IDLE);
    assign key    = $unsigned(item_reg.item_value);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // The values are kept distinct, so at most one cell matches and the
    // position is simply the OR of the matching slot indexes.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_match[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign hit       = |cell_match;
    assign is_insert = (item_reg.action == ACT_INSERT);
    assign is_delete = (item_reg.action == ACT_DELETE);
    assign do_ins    = is_insert && !hit && (count_reg != FULL_CNT);
    assign do_drop   = is_insert && !hit && (count_reg == FULL_CNT);
    assign do_del    = is_delete && hit;

    // A fresh insert lands at the slot equal to the count, which is below
    // CAPACITY and so fits the index width.
    always_comb
    begin
        if (hit)
        begin
            pos = hit_idx;
        end
        else if (do_ins)
        begin
            pos = count_reg[IDX_W-1:0];
        end
        else
        begin
            pos = '0;
        end
    end

    // Output logic of the controller.
    always_comb
    begin
        busy       = 1'b1;
        ctl        = '0;
        count_next = count_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        pos_wide   = {4'b0000, pos};
        cnt_wide   = {5'b00000, count_reg};
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_CMP:
            begin
                ctl.cmp = 1'b1;
            end
            ST_UPD:
            begin
                ctl.ins   = do_ins;
                ctl.del   = do_del;
                done_next = 1'b1;
                if (do_ins)
                begin
                    count_next = count_reg + 1'b1;
                end
                else if (do_del)
                begin
                    count_next = count_reg - 1'b1;
                end
                cnt_wide             = {5'b00000, count_next};
                res_next.was_present = hit;
                res_next.position    = pos_wide[3:0];
                res_next.entry_count = cnt_wide[4:0];
                res_next.dropped     = do_drop;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [DATA_W-1:0] upper;
            if (g + 1 < CAPACITY)
            begin : g_mid
                assign upper = cell_value[g + 1];
            end
            else
            begin : g_last
                assign upper = '0;
            end

            uvst_cell #(
                .INDEX (g),
                .IDX_W (IDX_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .key         (key),
                .upper_value (upper),
                .hit_idx     (hit_idx),
                .count       (count_reg),
                .value       (cell_value[g]),
                .match       (cell_match[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd;
        end
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
